/* hdl/ucr_pkg.sv */
`default_nettype none
package ucr_pkg;
    localparam int AtanLen = 24;
    localparam logic signed [33:0] Q30Pi     = 34'sd3373259426;
    localparam logic signed [34:0] Q30TwoPi  = 35'sd6746518852;
    localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [2:0] REG_START_X       = 3'd0;
    localparam logic [2:0] REG_START_Y       = 3'd1;
    localparam logic [2:0] REG_START_HEADING = 3'd2;
    localparam logic [2:0] REG_TIME_STEP     = 3'd3;
    localparam logic [2:0] REG_DECAY_GAIN    = 3'd4;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/unicycle_rollout_clf_constraint.sv */
`default_nettype none
// NSteps = min(CORDIC_STEPS, 24) CORDIC iterations are run; heading reduction
// first removes up to 20 whole turns of 2*pi.
// s_tready is low while an item is in work, so no new item is taken until the
// result is handed off. A single CORDIC stage iterates the heading; a single
// 36x32 multiplier is stepped by the sequencer for all products.
// Synchronous active-low reset restores register defaults and the start pose.
module unicycle_rollout_clf_constraint #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // speed, turn_rate, track_slack, ref_x, ref_y, ref_heading,
    // end_slack_x, end_slack_y, end_slack_heading (24 bits each)
    input  wire logic [215:0]  s_tdata,
    // first_step
    input  wire logic          s_tuser,
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // constraint_value, grad_speed, grad_turn, term_x_above, term_x_below,
    // term_y_above, term_y_below, term_heading_above, term_heading_below
    output logic [287:0]       m_tdata,
    output logic               m_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [23:0]   cfg_data
);
    import ucr_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_RED = 4'd1, ST_FOLD = 4'd2,
        ST_CORD = 4'd3, ST_MUL = 4'd4, ST_OUT = 4'd5;
    localparam int NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg;
    logic signed [23:0] sx_reg, sy_reg, sh_reg;
    logic [15:0] dt_reg, gain_reg;
    logic signed [23:0] px_reg, py_reg, ph_reg;
    logic signed [23:0] v_reg, w_reg, slk_reg, esx_reg, esy_reg, esh_reg;
    logic signed [24:0] ex_reg, ey_reg, eh_reg;
    logic last_reg;
    logic signed [37:0] a_reg;
    logic neg_reg;
    logic signed [35:0] cx_reg, cy_reg, cz_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [63:0] proj_reg, err_reg, vc_reg, vs_reg;
    logic signed [35:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] prod;
    logic signed [35:0] shx, shy, cord_x, cord_y;
    logic signed [63:0] drive;
    logic red_hi, red_lo;

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                               input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) r = 24'sh7FFFFF;
        else if (v < -64'sd8388608) r = 24'sh800000;
        else r = v[23:0];
        return r;
    endfunction

    // shared multiplier operand select, one product per cycle
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cnt_reg)
            5'd0: begin op_a = 36'(ex_reg); op_b = cx_reg[31:0]; end
            5'd1: begin op_a = 36'(ey_reg); op_b = cy_reg[31:0]; end
            5'd2: begin op_a = 36'(ex_reg); op_b = 32'(ex_reg); end
            5'd3: begin op_a = 36'(ey_reg); op_b = 32'(ey_reg); end
            5'd4: begin op_a = 36'(eh_reg); op_b = 32'(eh_reg); end
            5'd5: begin op_a = 36'(v_reg); op_b = proj_reg[31:0]; end
            5'd6: begin op_a = 36'(err_reg); op_b = {16'd0, gain_reg}; end
            5'd7: begin op_a = 36'(w_reg); op_b = 32'(eh_reg); end
            5'd8: begin op_a = 36'(v_reg); op_b = cx_reg[31:0]; end
            5'd9: begin op_a = 36'(v_reg); op_b = cy_reg[31:0]; end
            5'd10: begin op_a = 36'(vc_reg); op_b = {16'd0, dt_reg}; end
            5'd11: begin op_a = 36'(vs_reg); op_b = {16'd0, dt_reg}; end
            5'd12: begin op_a = 36'(w_reg); op_b = {16'd0, dt_reg}; end
            default: ;
        endcase
        prod = 64'(op_a) * 64'(op_b);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_RED;
            ST_RED:  if (!red_hi && !red_lo) state_next = ST_FOLD;
            ST_FOLD: state_next = ST_CORD;
            ST_CORD: if (cnt_reg == 5'(NSteps - 1) || NSteps == 0) state_next = ST_MUL;
            ST_MUL:  if (cnt_reg == 5'd15) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        shx = cx_reg >>> cnt_reg;
        shy = cy_reg >>> cnt_reg;
        if (cz_reg >= 0) begin
            cord_x = cx_reg - shy;
            cord_y = cy_reg + shx;
        end else begin
            cord_x = cx_reg + shy;
            cord_y = cy_reg - shx;
        end
        // bring into [-pi, pi), one turn per cycle
        red_hi = (a_reg >= 38'(Q30Pi));
        red_lo = (a_reg < -38'(Q30Pi));
        drive = rsh(acc_reg, 15);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            sx_reg <= 24'sd65536; sy_reg <= 24'sd65536; sh_reg <= '0;
            dt_reg <= 16'd3277; gain_reg <= 16'd512;
            px_reg <= 24'sd65536; py_reg <= 24'sd65536; ph_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_START_X:       sx_reg <= cfg_data;
                    REG_START_Y:       sy_reg <= cfg_data;
                    REG_START_HEADING: sh_reg <= cfg_data;
                    REG_TIME_STEP:     dt_reg <= cfg_data[15:0];
                    REG_DECAY_GAIN:    gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    v_reg <= s_tdata[23:0]; w_reg <= s_tdata[47:24];
                    slk_reg <= s_tdata[71:48];
                    esx_reg <= s_tdata[167:144]; esy_reg <= s_tdata[191:168];
                    esh_reg <= s_tdata[215:192];
                    last_reg <= s_tlast;
                    if (s_tuser) begin
                        px_reg <= sx_reg; py_reg <= sy_reg; ph_reg <= sh_reg;
                        ex_reg <= 25'(sx_reg) - 25'($signed(s_tdata[95:72]));
                        ey_reg <= 25'(sy_reg) - 25'($signed(s_tdata[119:96]));
                        eh_reg <= 25'(sh_reg) - 25'($signed(s_tdata[143:120]));
                        a_reg <= 38'(sh_reg) <<< 14;
                    end else begin
                        ex_reg <= 25'(px_reg) - 25'($signed(s_tdata[95:72]));
                        ey_reg <= 25'(py_reg) - 25'($signed(s_tdata[119:96]));
                        eh_reg <= 25'(ph_reg) - 25'($signed(s_tdata[143:120]));
                        a_reg <= 38'(ph_reg) <<< 14;
                    end
                end
                ST_RED: begin
                    if (red_hi) begin
                        a_reg <= a_reg - 38'(Q30TwoPi);
                    end else if (red_lo) begin
                        a_reg <= a_reg + 38'(Q30TwoPi);
                    end
                end
                ST_FOLD: begin
                    cnt_reg <= '0;
                    cx_reg <= 36'(CordicGain); cy_reg <= '0;
                    if (a_reg > 38'(Q30HalfPi)) begin
                        cz_reg <= 36'(a_reg - 38'(Q30Pi)); neg_reg <= 1'b1;
                    end else if (a_reg < -38'(Q30HalfPi)) begin
                        cz_reg <= 36'(a_reg + 38'(Q30Pi)); neg_reg <= 1'b1;
                    end else begin
                        cz_reg <= 36'(a_reg); neg_reg <= 1'b0;
                    end
                end
                ST_CORD: begin
                    // flip the quadrant on the final iteration
                    if (cnt_reg == 5'(NSteps - 1) && neg_reg) begin
                        cx_reg <= -cord_x; cy_reg <= -cord_y;
                    end else begin
                        cx_reg <= cord_x; cy_reg <= cord_y;
                    end
                    if (cz_reg >= 0) begin
                        cz_reg <= cz_reg - 36'(atan_q30(cnt_reg));
                    end else begin
                        cz_reg <= cz_reg + 36'(atan_q30(cnt_reg));
                    end
                    if (cnt_reg == 5'(NSteps - 1)) begin
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    prod_reg <= prod;
                    case (cnt_reg)
                        5'd1: acc_reg <= prod_reg;
                        5'd2: proj_reg <= rsh(acc_reg + prod_reg, 30);
                        5'd3: acc_reg <= prod_reg;
                        5'd4: acc_reg <= acc_reg + prod_reg;
                        5'd5: err_reg <= rsh(acc_reg + prod_reg, 16);
                        5'd6: acc_reg <= prod_reg;
                        5'd7: err_reg <= rsh(prod_reg, 8);
                        5'd8: acc_reg <= acc_reg + prod_reg;
                        5'd9: vc_reg <= rsh(prod_reg, 30);
                        5'd10: vs_reg <= rsh(prod_reg, 30);
                        5'd11: px_reg <= sat24(64'(px_reg) + rsh(prod_reg, 16));
                        5'd12: py_reg <= sat24(64'(py_reg) + rsh(prod_reg, 16));
                        5'd13: ph_reg <= sat24(64'(ph_reg) + rsh(prod_reg, 16));
                        default: ;
                    endcase
                end
                default: cnt_reg <= '0;
            endcase
        end
    end

    logic signed [63:0] exw, eyw, ehw;
    assign exw = 64'(ex_reg);
    assign eyw = 64'(ey_reg);
    assign ehw = 64'(eh_reg);
    always_comb begin
        m_tdata = '0;
        m_tdata[31:0]  = sat32(drive + err_reg - 64'(slk_reg));
        m_tdata[63:32] = sat32(2 * proj_reg);
        m_tdata[95:64] = sat32(2 * ehw);
        if (last_reg) begin
            m_tdata[127:96]  = sat32(exw - 64'(esx_reg));
            m_tdata[159:128] = sat32(-exw - 64'(esx_reg));
            m_tdata[191:160] = sat32(eyw - 64'(esy_reg));
            m_tdata[223:192] = sat32(-eyw - 64'(esy_reg));
            m_tdata[255:224] = sat32(ehw - 64'(esh_reg));
            m_tdata[287:256] = sat32(-ehw - 64'(esh_reg));
        end
    end
    assign m_tlast = last_reg;

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted twice");
`endif
endmodule
`default_nettype wire
